// ===== hdl/frsp_pkg.sv =====
package frsp_pkg;

  typedef enum logic [2:0] {
    PH_HEADER = 3'd0,
    PH_RECHDR = 3'd1,
    PH_DEF    = 3'd2,
    PH_DATA   = 3'd3,
    PH_FINISH = 3'd4,
    PH_DONE   = 3'd5
  } phase_t;

  localparam logic [1:0] KIND_HEADER = 2'd0;
  localparam logic [1:0] KIND_VALUE  = 2'd1;
  localparam logic [1:0] KIND_DEF    = 2'd2;
  localparam logic [1:0] KIND_END    = 2'd3;

  typedef struct packed {
    logic [1:0]  kind;
    logic        header_ok;
    logic [3:0]  local_type;
    logic [15:0] global_message;
    logic [7:0]  field_number;
    logic [7:0]  base_type;
    logic [63:0] field_value;
    logic [7:0]  field_position;
    logic        last_field;
    logic [15:0] running_check;
  } result_t;

  function automatic logic [15:0] nib_tab(input logic [3:0] n);
    logic [15:0] t;
    case (n)
      4'h0: t = 16'h0000;
      4'h1: t = 16'hCC01;
      4'h2: t = 16'hD801;
      4'h3: t = 16'h1400;
      4'h4: t = 16'hF001;
      4'h5: t = 16'h3C00;
      4'h6: t = 16'h2800;
      4'h7: t = 16'hE401;
      4'h8: t = 16'hA001;
      4'h9: t = 16'h6C00;
      4'hA: t = 16'h7800;
      4'hB: t = 16'hB401;
      4'hC: t = 16'h5000;
      4'hD: t = 16'h9C01;
      4'hE: t = 16'h8801;
      default: t = 16'h4400;
    endcase
    return t;
  endfunction

  function automatic logic [15:0] crc_nib(input logic [15:0] c, input logic [3:0] n);
    return ((c >> 4) & 16'h0FFF) ^ nib_tab(c[3:0]) ^ nib_tab(n);
  endfunction

  function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] b);
    return crc_nib(crc_nib(c, b[3:0]), b[7:4]);
  endfunction

endpackage

// ===== hdl/fit_record_stream_parser_unit.sv =====
// Results are registered: a result appears on out_* in the cycle after the byte that completes it.
// Throughput: one byte per cycle while in_ready is high (no result held or out_ready high);
// the field-store read for the next data byte is issued as the current byte is taken, from the cursor that it leaves.
// Reset: rst_n synchronous active low clears phase, counters, CRC and the
// per-type field counts; the field store is not cleared and needs no sweep.
module fit_record_stream_parser_unit #(
  parameter int LOCAL_TYPES     = 16,
  parameter int MAX_FIELDS      = 255,
  parameter int MAX_VALUE_BYTES = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_kind,
  output logic        out_header_ok,
  output logic [3:0]  out_local_type,
  output logic [15:0] out_global_message,
  output logic [7:0]  out_field_number,
  output logic [7:0]  out_base_type,
  output logic [63:0] out_field_value,
  output logic [7:0]  out_field_position,
  output logic        out_last_field,
  output logic [15:0] out_running_check
);
  localparam int DEPTH = LOCAL_TYPES * MAX_FIELDS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LW    = (LOCAL_TYPES > 1) ? $clog2(LOCAL_TYPES) : 1;

  frsp_pkg::phase_t phase_r, phase_nxt;
  logic [7:0]  byte_count_r, byte_count_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [15:0] shcrc_r, shcrc_nxt;
  logic [31:0] left_r, left_nxt;
  logic [3:0]  cur_r, cur_nxt;
  logic [7:0]  total_r, total_nxt;
  logic [7:0]  cursor_r, cursor_nxt;
  logic [7:0]  bif_r, bif_nxt;
  logic [63:0] acc_r, acc_nxt;
  logic [7:0]  dcount_r [LOCAL_TYPES];
  logic [15:0] dglob_r [LOCAL_TYPES];

  frsp_pkg::result_t res_r, res_nxt;
  logic out_valid_r;
  logic emit;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [23:0]   wdata, rdata;

  frsp_defmem #(.DEPTH(DEPTH), .AW(AW)) u_mem (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .raddr(raddr), .rdata(rdata)
  );

  logic take;
  assign in_ready = !out_valid_r || out_ready;
  assign take     = in_valid && in_ready;

  logic        valid_lt;
  logic [LW-1:0] lt_idx, b_idx;
  logic [7:0]  cnt_sel;
  logic [23:0] entry;
  logic [15:0] crc_b;
  logic        more;
  assign valid_lt = (32'(cur_r) < LOCAL_TYPES);
  assign lt_idx   = cur_r[LW-1:0];
  assign b_idx    = in_byte[LW-1:0];
  assign crc_b    = frsp_pkg::crc_byte(crc_r, in_byte);
  assign entry    = rdata;

  // Read address for next data byte: based on where cursor lands after this byte.
  always_comb begin
    logic [AW+8:0] a;
    a = (AW+9)'(cur_nxt[LW-1:0]) * (AW+9)'(MAX_FIELDS) + (AW+9)'(cursor_nxt);
    raddr = a[AW-1:0];
  end

  always_comb begin
    logic [7:0]  wsize;
    logic [AW+8:0] wa;
    logic [7:0]  sz, bif1;
    logic        last;
    phase_nxt      = phase_r;
    byte_count_nxt = byte_count_r;
    crc_nxt        = crc_r;
    shcrc_nxt      = shcrc_r;
    left_nxt       = left_r;
    cur_nxt        = cur_r;
    total_nxt      = total_r;
    cursor_nxt     = cursor_r;
    bif_nxt        = bif_r;
    acc_nxt        = acc_r;
    res_nxt        = '0;
    res_nxt.header_ok = 1'b1;
    emit           = 1'b0;
    we             = 1'b0;
    cnt_sel        = 8'd0;
    wsize          = acc_r[15:8];
    wa = (AW+9)'(lt_idx) * (AW+9)'(MAX_FIELDS) + (AW+9)'(dcount_r[lt_idx]);
    waddr          = wa[AW-1:0];
    wdata          = {in_byte, acc_r[15:0]};
    sz             = entry[15:8];
    bif1           = bif_r + 8'd1;
    last           = ({1'b0, cursor_r} + 9'd1) >= {1'b0, total_r};
    more           = !(left_r == 32'd0 || left_r[31]);
    if (take) begin
      unique case (phase_r)
        frsp_pkg::PH_HEADER: begin
          if (byte_count_r < 8'd12) crc_nxt = crc_b;
          if (byte_count_r >= 8'd4 && byte_count_r <= 8'd7)
            left_nxt = left_r | (32'(in_byte) << {byte_count_r[1:0], 3'b000});
          if (byte_count_r == 8'd12) shcrc_nxt = {8'h00, in_byte};
          if (byte_count_r == 8'd13) begin
            shcrc_nxt = {in_byte, shcrc_r[7:0]};
            crc_nxt = frsp_pkg::crc_byte(frsp_pkg::crc_byte(crc_r, shcrc_r[7:0]), in_byte);
            emit = 1'b1;
            res_nxt.kind = frsp_pkg::KIND_HEADER;
            res_nxt.header_ok = (crc_r == {in_byte, shcrc_r[7:0]});
            res_nxt.running_check = crc_nxt;
            if (res_nxt.header_ok)
              phase_nxt = more ? frsp_pkg::PH_RECHDR : frsp_pkg::PH_FINISH;
            else
              phase_nxt = frsp_pkg::PH_DONE;
          end else begin
            byte_count_nxt = byte_count_r + 8'd1;
          end
        end
        frsp_pkg::PH_RECHDR: begin
          crc_nxt  = crc_b;
          left_nxt = left_r - 32'd1;
          cur_nxt  = in_byte[3:0];
          more     = !(left_nxt == 32'd0 || left_nxt[31]);
          if (in_byte[7:4] != 4'd0) begin
            phase_nxt = frsp_pkg::PH_DEF;
            byte_count_nxt = 8'd0;
            acc_nxt = '0;
          end else begin
            cnt_sel = (32'(in_byte[3:0]) < LOCAL_TYPES) ? dcount_r[b_idx] : 8'd0;
            if (cnt_sel == 8'd0) begin
              phase_nxt = more ? frsp_pkg::PH_RECHDR : frsp_pkg::PH_FINISH;
            end else begin
              total_nxt = cnt_sel;
              cursor_nxt = 8'd0;
              bif_nxt = 8'd0;
              acc_nxt = '0;
              phase_nxt = frsp_pkg::PH_DATA;
            end
          end
        end
        frsp_pkg::PH_DATA: begin
          crc_nxt  = crc_b;
          left_nxt = left_r - 32'd1;
          more     = !(left_nxt == 32'd0 || left_nxt[31]);
          if (!valid_lt || 32'(cursor_r) >= MAX_FIELDS) begin
            phase_nxt = more ? frsp_pkg::PH_RECHDR : frsp_pkg::PH_FINISH;
          end else begin
            if (32'(bif_r) < MAX_VALUE_BYTES)
              acc_nxt = acc_r | (64'(in_byte) << {bif_r[2:0], 3'b000});
            bif_nxt = bif1;
            if (bif1 >= sz) begin
              emit = 1'b1;
              res_nxt.kind = frsp_pkg::KIND_VALUE;
              res_nxt.local_type = cur_r;
              res_nxt.global_message = dglob_r[lt_idx];
              res_nxt.field_number = entry[7:0];
              res_nxt.base_type = entry[23:16];
              res_nxt.field_value = acc_nxt;
              res_nxt.field_position = cursor_r;
              res_nxt.last_field = last;
              res_nxt.running_check = crc_nxt;
              cursor_nxt = cursor_r + 8'd1;
              bif_nxt = 8'd0;
              acc_nxt = '0;
              if (last) phase_nxt = more ? frsp_pkg::PH_RECHDR : frsp_pkg::PH_FINISH;
            end
          end
        end
        frsp_pkg::PH_DEF: begin
          crc_nxt  = crc_b;
          left_nxt = left_r - 32'd1;
          more     = !(left_nxt == 32'd0 || left_nxt[31]);
          if (byte_count_r < 8'd5) begin
            if (byte_count_r == 8'd2) acc_nxt = acc_r | (64'(in_byte) << 16);
            else if (byte_count_r == 8'd3) acc_nxt = acc_r | (64'(in_byte) << 24);
            else if (byte_count_r == 8'd4) begin
              total_nxt = in_byte;
              cursor_nxt = 8'd0;
              bif_nxt = 8'd0;
              if (in_byte == 8'd0) emit = 1'b1;
            end
            byte_count_nxt = byte_count_r + 8'd1;
          end else if (bif_r == 8'd0) begin
            acc_nxt = {acc_r[63:16], 8'h00, in_byte};
            bif_nxt = 8'd1;
          end else if (bif_r == 8'd1) begin
            acc_nxt = {acc_r[63:16], in_byte, acc_r[7:0]};
            bif_nxt = 8'd2;
          end else begin
            if (valid_lt && wsize != 8'd0 && 32'(dcount_r[lt_idx]) < MAX_FIELDS) we = 1'b1;
            bif_nxt = 8'd0;
            cursor_nxt = cursor_r + 8'd1;
            if (cursor_nxt >= total_r) emit = 1'b1;
          end
          if (emit) begin
            res_nxt.kind = frsp_pkg::KIND_DEF;
            res_nxt.local_type = cur_r;
            res_nxt.global_message = acc_nxt[31:16];
            res_nxt.running_check = crc_nxt;
            phase_nxt = more ? frsp_pkg::PH_RECHDR : frsp_pkg::PH_FINISH;
          end
        end
        frsp_pkg::PH_FINISH: begin
          emit = 1'b1;
          res_nxt.kind = frsp_pkg::KIND_END;
          res_nxt.running_check = crc_r;
          phase_nxt = frsp_pkg::PH_DONE;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= frsp_pkg::PH_HEADER;
      byte_count_r <= '0;
      crc_r        <= '0;
      shcrc_r      <= '0;
      left_r       <= '0;
      cur_r        <= '0;
      total_r      <= '0;
      cursor_r     <= '0;
      bif_r        <= '0;
      acc_r        <= '0;
      out_valid_r  <= 1'b0;
      for (int i = 0; i < LOCAL_TYPES; i++) begin
        dcount_r[i] <= '0;
        dglob_r[i]  <= '0;
      end
    end else begin
      phase_r      <= phase_nxt;
      byte_count_r <= byte_count_nxt;
      crc_r        <= crc_nxt;
      shcrc_r      <= shcrc_nxt;
      left_r       <= left_nxt;
      cur_r        <= cur_nxt;
      total_r      <= total_nxt;
      cursor_r     <= cursor_nxt;
      bif_r        <= bif_nxt;
      acc_r        <= acc_nxt;
      if (take && phase_r == frsp_pkg::PH_DEF && valid_lt) begin
        if (byte_count_r == 8'd3) dglob_r[lt_idx] <= acc_nxt[31:16];
        if (byte_count_r == 8'd4) dcount_r[lt_idx] <= '0;
      end
      if (we) dcount_r[lt_idx] <= dcount_r[lt_idx] + 8'd1;
      if (take) out_valid_r <= emit;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && emit) res_r <= res_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_kind           = res_r.kind;
  assign out_header_ok      = res_r.header_ok;
  assign out_local_type     = res_r.local_type;
  assign out_global_message = res_r.global_message;
  assign out_field_number   = res_r.field_number;
  assign out_base_type      = res_r.base_type;
  assign out_field_value    = res_r.field_value;
  assign out_field_position = res_r.field_position;
  assign out_last_field     = res_r.last_field;
  assign out_running_check  = res_r.running_check;
endmodule

// ===== hdl/frsp_defmem.sv =====
module frsp_defmem #(
  parameter int DEPTH = 4080,
  parameter int AW    = 12
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [23:0]   wdata,
  input  logic [AW-1:0] raddr,
  output logic [23:0]   rdata
);
  logic [23:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== hdl/frsp_checker.sv =====
module frsp_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] out_kind,
  input logic       out_header_ok,
  input logic       out_last_field
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_kind))
    else $error("result dropped under stall");
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");
  a_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != frsp_pkg::KIND_HEADER |-> out_header_ok)
    else $error("header_ok low on non-header result");
  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != frsp_pkg::KIND_VALUE |-> !out_last_field)
    else $error("last_field on non-value result");
endmodule

bind fit_record_stream_parser_unit frsp_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_kind(out_kind),
  .out_header_ok(out_header_ok), .out_last_field(out_last_field)
);

// ===== tb/sv/fit_record_stream_checker.sv =====
module fit_record_stream_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  in_byte,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [1:0]  out_kind,
  input  logic        out_header_ok,
  input  logic [3:0]  out_local_type,
  input  logic [15:0] out_global_message,
  input  logic [7:0]  out_field_number,
  input  logic [7:0]  out_base_type,
  input  logic [63:0] out_field_value,
  input  logic [7:0]  out_field_position,
  input  logic        out_last_field,
  input  logic [15:0] out_running_check,
  output int          errors,
  output int          waiting
);

  localparam int NTYPES = 16;
  localparam int NFIELDS = 255;
  localparam int VALUE_BYTES = 8;

  localparam logic [15:0] CRC_TAB [16] = '{
    16'h0000, 16'hCC01, 16'hD801, 16'h1400, 16'hF001, 16'h3C00, 16'h2800, 16'hE401,
    16'hA001, 16'h6C00, 16'h7800, 16'hB401, 16'h5000, 16'h9C01, 16'h8801, 16'h4400
  };

  frsp_pkg::phase_t  ph;
  logic [7:0]  hdr_cnt;
  logic [15:0] crc;
  logic [15:0] hdr_crc;
  logic [31:0] remaining;
  logic [3:0]  cur_type;
  logic [7:0]  n_fields;
  logic [7:0]  cursor;
  logic [7:0]  byte_idx;
  logic [63:0] accum;
  logic [23:0] field_defs [NTYPES][NFIELDS];
  logic [7:0]  field_cnt [NTYPES];
  logic [15:0] type_global [NTYPES];
  frsp_pkg::result_t pending_q [$];

  function automatic logic [15:0] crc_nibble(input logic [15:0] c, input logic [3:0] n);
    return ((c >> 4) & 16'h0FFF) ^ CRC_TAB[c[3:0]] ^ CRC_TAB[n];
  endfunction

  function automatic logic [15:0] crc_update(input logic [15:0] c, input logic [7:0] b);
    return crc_nibble(crc_nibble(c, b[3:0]), b[7:4]);
  endfunction

  function automatic frsp_pkg::phase_t after_record();
    return (remaining == 0 || remaining[31]) ? frsp_pkg::PH_FINISH : frsp_pkg::PH_RECHDR;
  endfunction

  function automatic void expect_result(input frsp_pkg::result_t r);
    pending_q = {pending_q, r};
  endfunction

  function automatic frsp_pkg::result_t def_done();
    frsp_pkg::result_t r;
    r = '0;
    r.kind = frsp_pkg::KIND_DEF;
    r.header_ok = 1'b1;
    r.local_type = cur_type;
    r.global_message = accum[31:16];
    r.running_check = crc;
    return r;
  endfunction

  // Advance the parser by one byte and queue the result it causes, if any.
  task automatic parse_byte(input logic [7:0] b);
    frsp_pkg::result_t r;
    logic [23:0] ent;
    logic        ok;
    r = '0;
    case (ph)
      frsp_pkg::PH_HEADER: begin
        if (hdr_cnt < 12) crc = crc_update(crc, b);
        if (hdr_cnt >= 4 && hdr_cnt <= 7) remaining[8*(hdr_cnt-4) +: 8] = b;
        if (hdr_cnt == 12) hdr_crc = {8'h00, b};
        if (hdr_cnt == 13) begin
          hdr_crc[15:8] = b;
          ok = (crc == hdr_crc);
          crc = crc_update(crc, hdr_crc[7:0]);
          crc = crc_update(crc, b);
          r.kind = frsp_pkg::KIND_HEADER;
          r.header_ok = ok;
          r.running_check = crc;
          expect_result(r);
          ph = ok ? after_record() : frsp_pkg::PH_DONE;
        end else begin
          hdr_cnt++;
        end
      end
      frsp_pkg::PH_RECHDR: begin
        crc = crc_update(crc, b);
        remaining--;
        cur_type = b[3:0];
        if (b[7:4] != 0) begin
          ph = frsp_pkg::PH_DEF;
          hdr_cnt = 0;
          accum = '0;
        end else if (field_cnt[cur_type] == 0) begin
          ph = after_record();
        end else begin
          n_fields = field_cnt[cur_type];
          cursor = 0;
          byte_idx = 0;
          accum = '0;
          ph = frsp_pkg::PH_DATA;
        end
      end
      frsp_pkg::PH_DEF: begin
        crc = crc_update(crc, b);
        remaining--;
        if (hdr_cnt < 5) begin
          if (hdr_cnt == 2) accum[23:16] = b;
          else if (hdr_cnt == 3) begin
            accum[31:24] = b;
            type_global[cur_type] = accum[31:16];
          end else if (hdr_cnt == 4) begin
            n_fields = b;
            cursor = 0;
            byte_idx = 0;
            field_cnt[cur_type] = 0;
            if (b == 0) begin
              expect_result(def_done());
              ph = after_record();
            end
          end
          hdr_cnt++;
        end else if (byte_idx == 0) begin
          accum[15:0] = {8'h00, b};
          byte_idx = 1;
        end else if (byte_idx == 1) begin
          accum[15:8] = b;
          byte_idx = 2;
        end else begin
          // Zero-size fields and fields past the table size are parsed, not kept.
          if (accum[15:8] != 0 && field_cnt[cur_type] < NFIELDS) begin
            field_defs[cur_type][field_cnt[cur_type]] = {b, accum[15:0]};
            field_cnt[cur_type]++;
          end
          byte_idx = 0;
          cursor++;
          if (cursor >= n_fields) begin
            expect_result(def_done());
            ph = after_record();
          end
        end
      end
      frsp_pkg::PH_DATA: begin
        crc = crc_update(crc, b);
        remaining--;
        if (cursor >= NFIELDS) begin
          ph = after_record();
        end else begin
          ent = field_defs[cur_type][cursor];
          if (byte_idx < VALUE_BYTES) accum[8*byte_idx +: 8] = b;
          byte_idx++;
          if (byte_idx >= ent[15:8]) begin
            r.kind = frsp_pkg::KIND_VALUE;
            r.header_ok = 1'b1;
            r.local_type = cur_type;
            r.global_message = type_global[cur_type];
            r.field_number = ent[7:0];
            r.base_type = ent[23:16];
            r.field_value = accum;
            r.field_position = cursor;
            r.last_field = (cursor + 9'd1 >= {1'b0, n_fields});
            r.running_check = crc;
            expect_result(r);
            cursor++;
            byte_idx = 0;
            accum = '0;
            if (r.last_field) ph = after_record();
          end
        end
      end
      frsp_pkg::PH_FINISH: begin
        r.kind = frsp_pkg::KIND_END;
        r.header_ok = 1'b1;
        r.running_check = crc;
        expect_result(r);
        ph = frsp_pkg::PH_DONE;
      end
      default: ;
    endcase
  endtask

  initial begin
    errors = 0;
    ph = frsp_pkg::PH_HEADER;
    hdr_cnt = 0;
    crc = 0;
    hdr_crc = 0;
    remaining = 0;
    cur_type = 0;
    n_fields = 0;
    cursor = 0;
    byte_idx = 0;
    accum = 0;
    for (int t = 0; t < NTYPES; t++) begin
      field_cnt[t] = 0;
      type_global[t] = 0;
    end
  end

  assign waiting = pending_q.size();

  always @(posedge clk) begin
    frsp_pkg::result_t got;
    frsp_pkg::result_t want;
    if (rst_n) begin
      // Compare first: a result at this edge comes from an earlier byte.
      if (out_valid && out_ready) begin
        got = '{out_kind, out_header_ok, out_local_type, out_global_message,
                out_field_number, out_base_type, out_field_value,
                out_field_position, out_last_field, out_running_check};
        if (pending_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("ERROR: unexpected result %h", got);
        end else begin
          want = pending_q.pop_front();
          if (got !== want) begin
            errors++;
            if (errors <= 10) begin
              $write("ERROR: result mismatch kind %0d/%0d ok %b/%b type %0d/%0d gm %h/%h ",
                     want.kind, got.kind, want.header_ok, got.header_ok,
                     want.local_type, got.local_type, want.global_message,
                     got.global_message);
              $display("fn %h/%h bt %h/%h val %h/%h pos %0d/%0d last %b/%b crc %h/%h",
                       want.field_number, got.field_number,
                       want.base_type, got.base_type, want.field_value, got.field_value,
                       want.field_position, got.field_position, want.last_field,
                       got.last_field, want.running_check, got.running_check);
            end
          end
        end
      end
      if (in_valid && in_ready) parse_byte(in_byte);
    end
  end

endmodule

// ===== tb/sv/tb_fit_record_stream_parser_unit.sv =====
module tb_fit_record_stream_parser_unit;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_byte;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  out_kind;
  logic        out_header_ok;
  logic [3:0]  out_local_type;
  logic [15:0] out_global_message;
  logic [7:0]  out_field_number;
  logic [7:0]  out_base_type;
  logic [63:0] out_field_value;
  logic [7:0]  out_field_position;
  logic        out_last_field;
  logic [15:0] out_running_check;
  int          errors;
  int          waiting;

  logic [7:0]  file_q [$];
  logic [7:0]  rec_q [$];
  int          size_tab [16][256];
  int          size_cnt [16];
  int          last_len;
  bit          quiet;
  bit          hold_due;

  fit_record_stream_parser_unit i_dut (.*);

  fit_record_stream_checker i_checker (.*);

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic void put_rec(input logic [7:0] b);
    rec_q = {rec_q, b};
  endfunction

  // Build a definition record; size_mode 0 picks small sizes with a few zero or long ones.
  task automatic add_def(input int ltype, input int nf, input int size_mode);
    int sz;
    put_rec({4'($urandom_range(1, 15)), 4'(ltype)});
    repeat (3) put_rec(8'($urandom));
    put_rec(8'($urandom));
    put_rec(8'(nf));
    size_cnt[ltype] = 0;
    for (int f = 0; f < nf; f++) begin
      case (size_mode)
        1: sz = 0;
        2: sz = (f % 6 == 5) ? 0 : (f % 6 == 4) ? $urandom_range(9, 12) : (1 << (f % 4));
        default: sz = ($urandom_range(0, 9) == 0) ? 0 :
                      ($urandom_range(0, 7) == 0) ? $urandom_range(9, 12) : $urandom_range(1, 4);
      endcase
      put_rec(8'($urandom));
      put_rec(8'(sz));
      put_rec(8'($urandom));
      if (sz != 0) begin
        size_tab[ltype][size_cnt[ltype]] = sz;
        size_cnt[ltype]++;
      end
    end
    last_len = 6 + 3 * nf;
  endtask

  // fill: 0 random, 1 all ones, 2 all zeros
  task automatic add_data(input int ltype, input int fill);
    int n;
    n = 1;
    put_rec({4'h0, 4'(ltype)});
    for (int f = 0; f < size_cnt[ltype]; f++)
      for (int k = 0; k < size_tab[ltype][f]; k++) begin
        put_rec(fill == 1 ? 8'hFF : fill == 2 ? 8'h00 : 8'($urandom));
        n++;
      end
    last_len = n;
  endtask

  task automatic send_byte(input logic [7:0] b, input bit may_idle);
    in_valid <= 1'b1;
    in_byte <= b;
    do @(posedge clk); while (!in_ready);
    if (may_idle && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
  endtask

  initial begin
    logic [15:0] hcrc;
    logic [31:0] sec_size;
    int          lt;
    in_valid = 1'b0;
    in_byte = '0;
    rst_n = 1'b0;
    quiet = 1'b0;
    hold_due = 1'b0;
    last_len = 0;
    for (int t = 0; t < 16; t++) size_cnt[t] = 0;

    // Directed records: empty definition, zero and long field sizes, extreme
    // values, a data record with no definition, all-zero-size definition.
    add_def(0, 0, 0);
    add_def(1, 6, 2);
    add_data(1, 1);
    add_data(1, 2);
    add_data(0, 0);
    add_data(5, 0);
    add_def(2, 3, 1);
    add_data(2, 0);
    add_def(15, 2, 0);
    add_data(15, 1);
    while (rec_q.size() < 430) begin
      lt = $urandom_range(0, 15);
      if ($urandom_range(0, 9) < 3) add_def(lt, $urandom_range(0, 9) == 0 ? 0 :
                                             $urandom_range(1, 6), 0);
      else if (size_cnt[lt] != 0 || $urandom_range(0, 4) == 0) add_data(lt, 0);
    end
    // Sometimes end the section inside the last record so the count wraps.
    sec_size = rec_q.size() - ((last_len > 1 && $urandom_range(0, 1)) ? 1 : 0);

    file_q = '{8'd14, 8'h20, 8'($urandom), 8'($urandom), sec_size[7:0], sec_size[15:8],
               sec_size[23:16], sec_size[31:24], 8'h2E, 8'h46, 8'h49, 8'h54};
    hcrc = '0;
    foreach (file_q[i]) hcrc = frsp_pkg::crc_byte(hcrc, file_q[i]);
    file_q = {file_q, hcrc[7:0], hcrc[15:8]};
    file_q = {file_q, rec_q};
    repeat (3) file_q = {file_q, 8'($urandom)};

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (file_q[i]) begin
      if (i == 150) hold_due = 1'b1;
      if (i == 260) begin
        // Pause until the results so far have drained.
        in_valid <= 1'b0;
        do @(posedge clk); while (waiting != 0);
      end
      if (file_q.size() - i < 60) quiet = 1'b1;
      send_byte(file_q[i], !quiet);
    end
    in_valid <= 1'b0;
    do @(posedge clk); while (waiting != 0);
    repeat (20) @(posedge clk);
    if (errors == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

  initial begin
    out_ready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_due) begin
        hold_due = 1'b0;
        out_ready <= 1'b0;
        repeat (80) @(posedge clk);
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
    end
  end

  initial begin
    #3000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
